[rtl/mwc_pkg.sv]
// ----------------------------------------------------------------------------
// mwc_pkg
// shared constants, types and arithmetic helpers for the multiply-with-carry
// noise generator
// ----------------------------------------------------------------------------
package mwc_pkg;

    localparam logic ACT_SEED = 1'b0;
    localparam logic ACT_NEXT = 1'b1;

    localparam logic [31:0] SEED_X = 32'd521288629;
    localparam logic [31:0] SEED_Y = 32'd362436069;

    localparam logic [15:0] MUL_X = 16'd18000;
    localparam logic [15:0] MUL_Y = 16'd30903;

    localparam logic [7:0] LUMA_MIN       = 8'd16;
    localparam logic [7:0] LUMA_MAX       = 8'd240;
    localparam logic [7:0] CHROMA_NEUTRAL = 8'd128;

    typedef struct packed {
        logic seed;
        logic step;
    } gen_ctrl_t;

    function automatic logic [31:0] mwc_advance(input logic [31:0] w, input logic [15:0] mul);
        logic [31:0] prod;
        prod = {16'h0000, mul} * {16'h0000, w[15:0]};
        return prod + {16'h0000, w[31:16]};
    endfunction

    function automatic logic [7:0] luma_clamp(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b < LUMA_MIN)
        begin
            r = LUMA_MIN;
        end
        else if (b > LUMA_MAX)
        begin
            r = LUMA_MAX;
        end
        return r;
    endfunction

endpackage

[rtl/mwc_gen.sv]
// ----------------------------------------------------------------------------
// mwc_gen
// holds the two multiply-with-carry words, seeds or advances them and forms
// the luma byte and audio sample of the advanced word
// ----------------------------------------------------------------------------
module mwc_gen (
    input  logic               clk,
    input  logic               rst_n,
    input  mwc_pkg::gen_ctrl_t ctrl,
    input  logic [31:0]        seed_pos,
    output logic [7:0]         luma,
    output logic [15:0]        audio
);
    import mwc_pkg::*;

    logic [31:0] gen_x_reg;
    logic [31:0] gen_y_reg;
    logic [31:0] gen_x_next;
    logic [31:0] gen_y_next;
    logic [31:0] x_adv;
    logic [31:0] y_adv;
    logic [31:0] pos_shl;

    always_comb
    begin
        x_adv   = mwc_advance(gen_x_reg, MUL_X);
        y_adv   = mwc_advance(gen_y_reg, MUL_Y);
        pos_shl = {seed_pos[15:0], 16'h0000};
        gen_x_next = gen_x_reg;
        gen_y_next = gen_y_reg;
        if (ctrl.seed)
        begin
            gen_x_next = SEED_X + seed_pos - pos_shl;
            gen_y_next = SEED_Y - seed_pos + pos_shl;
        end
        else if (ctrl.step)
        begin
            gen_x_next = x_adv;
            gen_y_next = y_adv;
        end
    end

    // low half of the random word is the low half of the new y
    assign luma  = luma_clamp(y_adv[7:0]);
    assign audio = y_adv[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_x_reg <= SEED_X;
            gen_y_reg <= SEED_Y;
        end
        else
        begin
            gen_x_reg <= gen_x_next;
            gen_y_reg <= gen_y_next;
        end
    end

endmodule

[rtl/mwc_noise_generator.sv]
// ----------------------------------------------------------------------------
// mwc_noise_generator
// noise source from two 16-bit multiply-with-carry generators, giving a luma
// byte, a neutral chroma byte and a signed audio sample per next beat
// ----------------------------------------------------------------------------
// The block takes one beat per clock as long as out_ready keeps up. While a
// result waits on out_ready, a next beat behind it holds in the input register
// and in_ready drops until the result is taken; seed beats still pass. A beat
// goes through an input register, then one pass through the generator update
// (a 16x16 constant multiply and an add per word) into the result register, so
// out_valid rises when a next beat moves from the input register into the
// result register, and the result holds there until out_ready takes it. A
// seed beat reloads both generator words from frame_position and produces no
// result; a next beat advances both words and produces exactly one.
module mwc_noise_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic signed [31:0] frame_position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         luma,
    output logic [7:0]         chroma,
    output logic signed [15:0] audio_sample
);
    import mwc_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_action_reg;
    logic [31:0] s1_pos_reg;
    logic        s1_advance;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_load;
    logic [7:0]  luma_reg;
    logic [15:0] audio_reg;
    logic [7:0]  gen_luma;
    logic [15:0] gen_audio;
    gen_ctrl_t   ctrl;

    always_comb
    begin
        s1_advance = s1_valid_reg &&
                     (s1_action_reg == ACT_SEED || !out_valid_reg || out_ready);
        in_ready   = !s1_valid_reg || s1_advance;
        out_load   = s1_advance && s1_action_reg == ACT_NEXT;
        ctrl.seed  = s1_advance && s1_action_reg == ACT_SEED;
        ctrl.step  = out_load;

        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    mwc_gen u_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .seed_pos (s1_pos_reg),
        .luma     (gen_luma),
        .audio    (gen_audio)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_action_reg <= action;
            s1_pos_reg    <= frame_position;
        end
        if (out_load)
        begin
            luma_reg  <= gen_luma;
            audio_reg <= gen_audio;
        end
    end

    assign out_valid    = out_valid_reg;
    assign luma         = luma_reg;
    assign chroma       = CHROMA_NEUTRAL;
    assign audio_sample = audio_reg;

    // seed beat never produces a result
    a_seed_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.seed && !out_valid_reg) |=> !out_valid_reg)
        else $error("seed beat produced a result");

    // next beat always lands in the result register
    a_next_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("next beat lost");

    // empty input stage always takes a beat
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("empty input stage not ready");

    // luma stays within video range
    a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (luma_reg >= LUMA_MIN && luma_reg <= LUMA_MAX))
        else $error("luma out of range");

endmodule
